### design/contiguous_unit_allocator_defines.svh
// Assertion macros for the contiguous unit allocator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define CUA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CUA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/cua_pkg.sv
// Shared types, field widths and codes for the contiguous unit allocator.
// No dependencies.
package cua_pkg;
	localparam int DEF_MEM_UNITS  = 1024;
	localparam int DEF_TIMER_BITS = 16;

	localparam int OP_W     = 2;
	localparam int REQ_W    = 11;
	localparam int HOLD_W   = 16;
	localparam int LIM_W    = 11;
	localparam int STRAT_W  = 2;
	localparam int UNITS_W  = 11;
	localparam int POS_W    = 10;
	localparam int CNT_W    = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 11;

	localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [UNITS_W-1:0] UNITS_RESET = 11'd1024;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNITS    = 1'd1;

	typedef struct packed {
		logic tick;
		logic clear;
		logic write;
	} cell_cmd_t;
endpackage

### design/cua_cell.sv
// One timer cell of the rotating unit ring.
// Depends on cua_pkg for the command struct.
module cua_cell import cua_pkg::*; #(
	parameter int TIMER_BITS = DEF_TIMER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  cell_cmd_t             cmd,
	input  logic [TIMER_BITS-1:0] wdata,
	input  logic [TIMER_BITS-1:0] d,
	output logic [TIMER_BITS-1:0] q
);
	logic [TIMER_BITS-1:0] timer_q;
	logic [TIMER_BITS-1:0] nxt;

	always_comb begin
		if (cmd.clear) begin
			nxt = '0;
		end else if (cmd.write) begin
			nxt = wdata;
		end else if (cmd.tick && d != '0) begin
			nxt = d - 1'b1;
		end else begin
			nxt = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (shift) begin
			timer_q <= nxt;
		end
	end

	assign q = timer_q;
endmodule

### design/cua_scan.sv
// Free-run tracker fed one unit per cycle from the ring tail while step is high.
// Depends on cua_pkg for widths and strategy codes.
module cua_scan import cua_pkg::*; #(
	parameter int MEM_UNITS = DEF_MEM_UNITS,
	localparam int CW = $clog2(MEM_UNITS + 1),
	localparam int PW = $clog2(MEM_UNITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               step,
	input  logic [CW-1:0]      idx,
	input  logic               free,
	input  logic [CW-1:0]      n,
	input  logic [PW-1:0]      p,
	input  logic [REQ_W-1:0]   req,
	input  logic [LIM_W-1:0]   limit,
	input  logic [STRAT_W-1:0] strategy,
	output logic               ok,
	output logic [PW-1:0]      pos,
	output logic [CNT_W-1:0]   probes,
	output logic [CNT_W-1:0]   frags
);
	localparam int IW = (CW > REQ_W) ? CW : REQ_W;

	logic mfree;
	logic [IW-1:0] req_x, lim_x;

	logic in_h, fnd_h, in_l, fnd_l, in_b, fnd_b, stop_b, in_f;
	logic [PW-1:0] st_h, pos_h, st_l, pos_l, st_b, pos_b;
	logic [CW-1:0] len_h, len_l, len_b, blen_b, len_f;
	logic [CW-1:0] prb_h, prb_l, prb_b, frag_q;
	logic [CW:0] prb_sum;
	logic [31:0] prb_w, frag_w;

	assign mfree = free && (idx < n);
	assign req_x = IW'(req);
	assign lim_x = IW'(limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_h <= 1'b0; fnd_h <= 1'b0; st_h <= '0; pos_h <= '0; len_h <= '0; prb_h <= '0;
			in_l <= 1'b0; fnd_l <= 1'b0; st_l <= '0; pos_l <= '0; len_l <= '0; prb_l <= '0;
			in_b <= 1'b0; fnd_b <= 1'b0; st_b <= '0; pos_b <= '0; len_b <= '0; prb_b <= '0;
			stop_b <= 1'b0; blen_b <= '0;
			in_f <= 1'b0; len_f <= '0; frag_q <= '0;
		end else if (clr) begin
			in_h <= 1'b0; fnd_h <= 1'b0; prb_h <= '0;
			in_l <= 1'b0; fnd_l <= 1'b0; prb_l <= '0;
			in_b <= 1'b0; fnd_b <= 1'b0; prb_b <= '0; stop_b <= 1'b0;
			in_f <= 1'b0; frag_q <= '0;
		end else if (step) begin
			// runs starting at or above the pointer
			if (!fnd_h) begin
				if (in_h) begin
					if (mfree) begin
						len_h <= len_h + 1'b1;
					end else begin
						in_h <= 1'b0;
						if (IW'(len_h) >= req_x) begin
							fnd_h <= 1'b1;
							pos_h <= st_h;
						end
					end
				end else if (mfree && idx >= CW'(p)) begin
					in_h <= 1'b1; st_h <= PW'(idx); len_h <= CW'(1); prb_h <= prb_h + 1'b1;
				end
			end
			// runs starting below the pointer, free to reach past it
			if (!fnd_l) begin
				if (in_l) begin
					if (mfree) begin
						len_l <= len_l + 1'b1;
					end else begin
						in_l <= 1'b0;
						if (IW'(len_l) >= req_x) begin
							fnd_l <= 1'b1;
							pos_l <= st_l;
						end
					end
				end else if (mfree && idx < CW'(p)) begin
					in_l <= 1'b1; st_l <= PW'(idx); len_l <= CW'(1); prb_l <= prb_l + 1'b1;
				end
			end
			// best fit: keep shortest fitting run, stop on an exact one
			if (!stop_b) begin
				if (in_b) begin
					if (mfree) begin
						len_b <= len_b + 1'b1;
					end else begin
						in_b <= 1'b0;
						if (IW'(len_b) >= req_x && (!fnd_b || len_b < blen_b)) begin
							fnd_b <= 1'b1;
							blen_b <= len_b;
							pos_b <= st_b;
							if (IW'(len_b) == req_x) begin
								stop_b <= 1'b1;
							end
						end
					end
				end else if (mfree) begin
					in_b <= 1'b1; st_b <= PW'(idx); len_b <= CW'(1); prb_b <= prb_b + 1'b1;
				end
			end
			// fragment count over all runs no longer than the limit
			if (in_f) begin
				if (mfree) begin
					len_f <= len_f + 1'b1;
				end else begin
					in_f <= 1'b0;
					if (IW'(len_f) <= lim_x) begin
						frag_q <= frag_q + 1'b1;
					end
				end
			end else if (mfree) begin
				in_f <= 1'b1; len_f <= CW'(1);
			end
		end
	end

	always_comb begin
		prb_sum = '0;
		case (strategy)
			STRAT_BEST: begin
				ok = fnd_b; pos = pos_b; prb_sum = (CW+1)'(prb_b);
			end
			STRAT_NEXT: begin
				if (fnd_h) begin
					ok = 1'b1; pos = pos_h; prb_sum = (CW+1)'(prb_h);
				end else begin
					ok = fnd_l; pos = pos_l;
					prb_sum = (CW+1)'(prb_h) + (CW+1)'(prb_l);
				end
			end
			default: begin
				ok = fnd_h; pos = pos_h; prb_sum = (CW+1)'(prb_h);
			end
		endcase
	end

	assign prb_w  = 32'(prb_sum);
	assign frag_w = 32'(frag_q);
	assign probes = (prb_w > 32'(COUNT_MAX)) ? COUNT_MAX : prb_w[CNT_W-1:0];
	assign frags  = (frag_w > 32'(COUNT_MAX)) ? COUNT_MAX : frag_w[CNT_W-1:0];
endmodule

### design/contiguous_unit_allocator.sv
// Contiguous unit allocator top level: ring of timer cells, run tracker, sequencer.
// Depends on cua_pkg, cua_cell, cua_scan and contiguous_unit_allocator_defines.svh.
//
// Usage: raise start with operation and its fields; the request is taken when
// start is high and busy is low. Busy stays high until the result strobe done,
// which holds alloc_ok, start_position, runs_probed and fragment_total for
// exactly one cycle; the receiver cannot stall it.
// The unit timers live in a ring of MEM_UNITS cells that rotates one place per
// cycle while a pass runs, so every unit passes the ring tail once per pass.
// Tick, clear and count take one pass. An allocate takes one search pass, and
// on success a second pass stamps the run.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while idle.
// Reset clears every timer and the next-fit pointer, sets the strategy to first
// fit and units to 1024 at once; the block accepts requests right after reset.
`include "contiguous_unit_allocator_defines.svh"
module contiguous_unit_allocator import cua_pkg::*; #(
	parameter int MEM_UNITS  = DEF_MEM_UNITS,
	parameter int TIMER_BITS = DEF_TIMER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      operation,
	input  logic [REQ_W-1:0]     request_units,
	input  logic [HOLD_W-1:0]    hold_time,
	input  logic [LIM_W-1:0]     fragment_limit,
	output logic                 done,
	output logic                 alloc_ok,
	output logic [POS_W-1:0]     start_position,
	output logic [CNT_W-1:0]     runs_probed,
	output logic [CNT_W-1:0]     fragment_total,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);
	localparam int CW = $clog2(MEM_UNITS + 1);
	localparam int PW = $clog2(MEM_UNITS);
	localparam int IW = (CW > REQ_W) ? CW : REQ_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PASS  = 2'd1;
	localparam logic [1:0] S_EVAL  = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [STRAT_W-1:0] strat_q;
	logic [UNITS_W-1:0] units_q;
	logic [OP_W-1:0] op_q;
	logic [REQ_W-1:0] req_q;
	logic [TIMER_BITS-1:0] hold_q;
	logic [LIM_W-1:0] lim_q;
	logic [CW-1:0] n_q, idx_q, n_new;
	logic [PW-1:0] p_q, ptr_q, p_new;
	logic ok_q;
	logic done_q, res_ok_q;
	logic [POS_W-1:0] res_pos_q;
	logic [CNT_W-1:0] res_prb_q, res_frag_q;

	logic [TIMER_BITS-1:0] ring [MEM_UNITS];
	logic [TIMER_BITS-1:0] tail;
	logic shift, in_rng, accept, last, alloc_op;
	cell_cmd_t head_cmd;
	logic [31:0] hold_w, pos_w;
	logic [IW:0] run_end;

	logic sc_ok;
	logic [PW-1:0] sc_pos;
	logic [CNT_W-1:0] sc_prb, sc_frag;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign tail = ring[MEM_UNITS-1];
	assign last = (idx_q == CW'(MEM_UNITS - 1));
	assign hold_w = 32'(hold_time);
	assign pos_w = 32'(sc_pos);
	assign alloc_op = (op_q == OP_ALLOC) && (req_q != '0);

	always_comb begin
		if (units_q == '0) begin
			n_new = CW'(1);
		end else if ((IW + 1)'(units_q) > (IW + 1)'(MEM_UNITS)) begin
			n_new = CW'(MEM_UNITS);
		end else begin
			n_new = CW'(units_q);
		end
		if (strat_q == STRAT_NEXT && CW'(ptr_q) < n_new) begin
			p_new = ptr_q;
		end else begin
			p_new = '0;
		end
	end

	assign run_end = (IW + 1)'(sc_pos) + (IW + 1)'(req_q);
	assign in_rng = ((IW + 1)'(idx_q) >= (IW + 1)'(sc_pos)) && ((IW + 1)'(idx_q) < run_end);
	assign shift = (state_q == S_PASS && idx_q != CW'(MEM_UNITS)) || (state_q == S_WRITE);

	always_comb begin
		head_cmd = '0;
		if (state_q == S_PASS) begin
			head_cmd.tick  = (op_q == OP_TICK);
			head_cmd.clear = (op_q == OP_CLEAR);
		end else if (state_q == S_WRITE) begin
			head_cmd.write = in_rng;
		end
	end

	genvar k;
	generate
		for (k = 0; k < MEM_UNITS; k++) begin : g_ring
			if (k == 0) begin : g_head
				cua_cell #(.TIMER_BITS(TIMER_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift), .cmd(head_cmd),
					.wdata(hold_q), .d(tail), .q(ring[k])
				);
			end else begin : g_body
				cua_cell #(.TIMER_BITS(TIMER_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift), .cmd(cell_cmd_t'('0)),
					.wdata('0), .d(ring[k-1]), .q(ring[k])
				);
			end
		end
	endgenerate

	cua_scan #(.MEM_UNITS(MEM_UNITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .clr(accept), .step(state_q == S_PASS),
		.idx(idx_q), .free(tail == '0), .n(n_q), .p(p_q), .req(req_q),
		.limit(lim_q), .strategy(strat_q), .ok(sc_ok), .pos(sc_pos),
		.probes(sc_prb), .frags(sc_frag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_q <= STRAT_FIRST;
			units_q <= UNITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_STRATEGY) begin
				strat_q <= cfg_data[STRAT_W-1:0];
			end else begin
				units_q <= cfg_data[UNITS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			ptr_q <= '0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_PASS;
						idx_q <= '0;
					end
				end
				S_PASS: begin
					done_q <= 1'b0;
					if (idx_q == CW'(MEM_UNITS)) begin
						state_q <= S_EVAL;
					end
					idx_q <= idx_q + 1'b1;
				end
				S_EVAL: begin
					idx_q <= '0;
					ok_q <= alloc_op && sc_ok;
					if (alloc_op && sc_ok) begin
						state_q <= S_WRITE;
						done_q <= 1'b0;
					end else begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				S_WRITE: begin
					idx_q <= idx_q + 1'b1;
					done_q <= last;
					if (last) begin
						state_q <= S_IDLE;
						if (strat_q == STRAT_NEXT) begin
							ptr_q <= (run_end >= (IW + 1)'(n_q)) ? '0 : PW'(run_end);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// request fields and results: payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			req_q <= request_units;
			hold_q <= hold_w[TIMER_BITS-1:0];
			lim_q <= fragment_limit;
			n_q <= n_new;
			p_q <= p_new;
		end
		if (state_q == S_EVAL) begin
			res_ok_q <= alloc_op && sc_ok;
			res_pos_q <= (alloc_op && sc_ok) ? pos_w[POS_W-1:0] : '0;
			res_prb_q <= alloc_op ? sc_prb : '0;
			res_frag_q <= (op_q == OP_COUNT) ? sc_frag : '0;
		end
	end

	assign done = done_q;
	assign alloc_ok = res_ok_q;
	assign start_position = res_pos_q;
	assign runs_probed = res_prb_q;
	assign fragment_total = res_frag_q;

	`CUA_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`CUA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request not taken")
	`CUA_ASSERT_IMPL(a_fail_pos, clk, arst_n, done && !alloc_ok, start_position == '0, "fail pos")
	`CUA_ASSERT_IMPL(a_write_alloc, clk, arst_n, state_q == S_WRITE, op_q == OP_ALLOC && ok_q, "bad stamp")
endmodule
